// ----- rtl/dcmf_pkg.sv -----
// dcmf_pkg: shared types and constants of the dark channel minimum filter.
// Used by every module under rtl/ but dcmf_ram; depends on nothing.
package dcmf_pkg;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 13;
    localparam int RAD_W   = 3;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 2;
    // holds a row-window depth up to twice the largest supported radius
    localparam int DEPTH_W = 5;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    localparam int HEIGHT_MAX = 4096;

    localparam logic [COL_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [ROW_W-1:0] HEIGHT_RST = 13'd768;
    localparam logic [RAD_W-1:0] RADIUS_RST = 3'd7;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd2;

    // one pixel slot moving down the line-store chain
    typedef struct packed {
        logic               valid;
        logic               incol;   // column inside the image: touches the line store
        logic               clear;   // first column of a scan row: restart row window
        logic               res;     // slot produces a result
        logic               eor;
        logic               eof;
        logic [COL_W-1:0]   col;
        logic [PIX_W-1:0]   pix;
        logic [DEPTH_W-1:0] depth;   // rows above that take part in the column minimum
        logic [PIX_W-1:0]   part;    // running column minimum
    } dcmf_beat_t;

    function automatic logic [PIX_W-1:0] min8(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/dcmf_ram.sv -----
// dcmf_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/dcmf_cell.sv -----
// dcmf_cell: one line-store row of the vertical minimum chain.
// Depends on dcmf_pkg and dcmf_ram.
module dcmf_cell
    import dcmf_pkg::*;
#(
    parameter int INDEX     = 1,
    parameter int MAX_WIDTH = 1024
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  dcmf_beat_t       beat_i,
    input  logic [PIX_W-1:0] prev_q_i,   // row INDEX-1 above, same column
    output dcmf_beat_t       beat_o,
    output logic [PIX_W-1:0] q_o         // row INDEX above, for beat_o
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    dcmf_beat_t        beat_reg, beat_next;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [PIX_W-1:0]  wr_data_reg;
    logic              use_prev;

    always_comb begin
        use_prev  = (DEPTH_W'(INDEX - 1) <= beat_i.depth);
        beat_next = beat_i;
        if (use_prev) begin
            beat_next.part = min8(beat_i.part, prev_q_i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_reg.valid <= 1'b0;
            wr_pend_reg    <= 1'b0;
        end else if (adv) begin
            beat_reg.valid <= beat_next.valid;
            wr_pend_reg    <= beat_i.valid && beat_i.incol;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            beat_reg.incol <= beat_next.incol;
            beat_reg.clear <= beat_next.clear;
            beat_reg.res   <= beat_next.res;
            beat_reg.eor   <= beat_next.eor;
            beat_reg.eof   <= beat_next.eof;
            beat_reg.col   <= beat_next.col;
            beat_reg.pix   <= beat_next.pix;
            beat_reg.depth <= beat_next.depth;
            beat_reg.part  <= beat_next.part;
            wr_addr_reg    <= ADDR_W'(beat_i.col);
            wr_data_reg    <= prev_q_i;
        end
    end

    // write lands one step after the read of the same column, shifting the row down
    dcmf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_ram (
        .aclk (aclk),
        .we   (adv && wr_pend_reg),
        .waddr(wr_addr_reg),
        .wdata(wr_data_reg),
        .re   (adv && beat_i.valid && beat_i.incol),
        .raddr(ADDR_W'(beat_i.col)),
        .rdata(q_o)
    );

    assign beat_o = beat_reg;

endmodule

// ----- rtl/dcmf_hwin.sv -----
// dcmf_hwin: final column minimum and horizontal minimum window along the row.
// Depends on dcmf_pkg.
module dcmf_hwin
    import dcmf_pkg::*;
#(
    parameter int MAX_RADIUS = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             adv,
    input  dcmf_beat_t       beat_i,
    input  logic [PIX_W-1:0] q_i,        // deepest line-store row
    input  logic [RAD_W-1:0] radius,
    output logic             res_valid,
    output logic [PIX_W-1:0] dark,
    output logic             eor,
    output logic             eof
);

    localparam int NROWS  = 2 * MAX_RADIUS;
    localparam int WIN    = 2 * MAX_RADIUS + 1;
    localparam int LEAVES = 1 << $clog2(WIN);

    logic [PIX_W-1:0] win_reg [WIN];
    logic [PIX_W-1:0] win_next [WIN];
    logic             res_reg, eor_reg, eof_reg;
    logic [PIX_W-1:0] colmin;
    logic [PIX_W-1:0] tree [1:2*LEAVES-1];
    logic [DEPTH_W-1:0] span;

    always_comb begin
        colmin = beat_i.part;
        if (DEPTH_W'(NROWS) <= beat_i.depth) begin
            colmin = min8(beat_i.part, q_i);
        end
        if (!beat_i.incol) begin
            colmin = PIX_MAX;
        end
        win_next[0] = colmin;
        for (int i = 1; i < WIN; i++) begin
            win_next[i] = beat_i.clear ? PIX_MAX : win_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= 1'b0;
        end else if (adv) begin
            res_reg <= beat_i.valid && beat_i.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && beat_i.valid) begin
            win_reg <= win_next;
            eor_reg <= beat_i.eor;
            eof_reg <= beat_i.eof;
        end
    end

    // balanced min tree over the taps inside the current window side
    always_comb begin
        span = DEPTH_W'({radius, 1'b0});
        for (int i = 0; i < LEAVES; i++) begin
            tree[LEAVES+i] = PIX_MAX;
        end
        for (int i = 0; i < WIN; i++) begin
            if (DEPTH_W'(i) <= span) begin
                tree[LEAVES+i] = win_reg[i];
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            tree[n] = min8(tree[2*n], tree[2*n+1]);
        end
    end

    assign res_valid = res_reg;
    assign dark      = tree[1];
    assign eor       = eor_reg;
    assign eof       = eof_reg;

endmodule

// ----- rtl/dark_channel_min_filter.sv -----
// dark_channel_min_filter: top level of the dark channel erosion filter.
// Depends on dcmf_pkg, dcmf_cell (with dcmf_ram) and dcmf_hwin.
//
// Input stream s_*: one RGB pixel per transaction over an extended raster of
// (height+radius) rows by (width+radius) columns; pad pixels are ignored.
// Output stream m_*: one dark value per image pixel in raster order, tlast on
// the last pixel of each image row, tuser on the last pixel of the frame.
// Configuration: plain write port, applied while idle by the user (the block
// does not enforce it); any write restarts the frame scan. Effective width,
// height and radius are clamped to their ranges. Throughput: one pixel per
// clock while the skid register is empty; the 2*MAX_RADIUS line store cells,
// each with one RAM read and one write per pixel, set it. Path: head register,
// cells, hwin and output registers, plus radius rows and cols of raster delay.
// Stall: the whole pipeline holds while the output skid register is full;
// s_tready is registered-style (skid empty) and stays high while one result
// waits in the output register.
// Reset: scan position back to the frame start, registers to 1024 x 768,
// radius 7, pipeline and output empty. No clearing pass: line store rows are
// masked until the current frame has written them.
module dark_channel_min_filter
    import dcmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    // config write port
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // pixel input
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,    // red[7:0], green[15:8], blue[23:16]
    // dark value output
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,    // dark_value[7:0]
    output logic             m_tlast,    // end_of_row
    output logic [0:0]       m_tuser     // end_of_frame[0]
);

    localparam int NROWS = 2 * MAX_RADIUS;

    logic [COL_W-1:0] width_cfg_reg;
    logic [ROW_W-1:0] height_cfg_reg;
    logic [RAD_W-1:0] radius_cfg_reg;
    logic [COL_W-1:0] scan_col_reg, scan_col_next;
    logic [ROW_W-1:0] scan_row_reg, scan_row_next;

    logic [COL_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [RAD_W-1:0] r_eff;

    logic             adv;
    logic             accept;
    dcmf_beat_t       head_beat;
    dcmf_beat_t       b1_reg;

    logic [PIX_W-1:0] red, green, blue;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    logic [3:0]       two_r;
    logic [COL_W:0]   col_inc, col_end;
    logic [ROW_W:0]   row_inc, row_end;

    dcmf_beat_t       beat_chain [NROWS+1];
    logic [PIX_W-1:0] q_chain [NROWS+1];

    logic             hw_valid, hw_eor, hw_eof;
    logic [PIX_W-1:0] hw_dark;
    logic             push, pop;

    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_dark_reg, out_dark_next;
    logic             out_eor_reg, out_eor_next;
    logic             out_eof_reg, out_eof_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [PIX_W-1:0] skid_dark_reg, skid_dark_next;
    logic             skid_eor_reg, skid_eor_next;
    logic             skid_eof_reg, skid_eof_next;

    // effective configuration
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = COL_W'(1);
        end else if (int'(width_cfg_reg) > MAX_WIDTH) begin
            w_eff = COL_W'(MAX_WIDTH);
        end else begin
            w_eff = width_cfg_reg;
        end
        if (height_cfg_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (int'(height_cfg_reg) > HEIGHT_MAX) begin
            h_eff = ROW_W'(HEIGHT_MAX);
        end else begin
            h_eff = height_cfg_reg;
        end
        if (int'(radius_cfg_reg) > MAX_RADIUS) begin
            r_eff = RAD_W'(MAX_RADIUS);
        end else begin
            r_eff = radius_cfg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RST;
            height_cfg_reg <= HEIGHT_RST;
            radius_cfg_reg <= RADIUS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WIDTH:  width_cfg_reg  <= cfg_wr_data[COL_W-1:0];
                REG_HEIGHT: height_cfg_reg <= cfg_wr_data[ROW_W-1:0];
                REG_RADIUS: radius_cfg_reg <= cfg_wr_data[RAD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    // head: classify the scan position and advance it
    always_comb begin
        orow  = scan_row_reg - ROW_W'(r_eff);
        ocol  = scan_col_reg - COL_W'(r_eff);
        two_r = {r_eff, 1'b0};

        head_beat.valid = s_tvalid;
        head_beat.incol = (scan_col_reg < w_eff);
        head_beat.clear = (scan_col_reg == '0);
        head_beat.res   = (scan_row_reg >= ROW_W'(r_eff)) && (scan_col_reg >= COL_W'(r_eff))
                          && (orow < h_eff) && (ocol < w_eff);
        head_beat.eor   = (ocol == w_eff - COL_W'(1));
        head_beat.eof   = head_beat.eor && (orow == h_eff - ROW_W'(1));
        head_beat.col   = scan_col_reg;
        head_beat.pix   = (scan_row_reg < h_eff) ? min8(min8(red, green), blue) : PIX_MAX;
        if (scan_row_reg >= ROW_W'(two_r)) begin
            head_beat.depth = DEPTH_W'(two_r);
        end else begin
            head_beat.depth = DEPTH_W'(scan_row_reg);
        end
        head_beat.part  = PIX_MAX;

        col_inc = {1'b0, scan_col_reg} + (COL_W+1)'(1);
        col_end = {1'b0, w_eff} + (COL_W+1)'(r_eff);
        row_inc = {1'b0, scan_row_reg} + (ROW_W+1)'(1);
        row_end = {1'b0, h_eff} + (ROW_W+1)'(r_eff);

        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        if (cfg_wr_en) begin
            scan_col_next = '0;
            scan_row_next = '0;
        end else if (accept) begin
            if (col_inc >= col_end) begin
                scan_col_next = '0;
                scan_row_next = (row_inc >= row_end) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                scan_col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            b1_reg.valid <= 1'b0;
        end else begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            if (adv) begin
                b1_reg.valid <= head_beat.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_reg.incol <= head_beat.incol;
            b1_reg.clear <= head_beat.clear;
            b1_reg.res   <= head_beat.res;
            b1_reg.eor   <= head_beat.eor;
            b1_reg.eof   <= head_beat.eof;
            b1_reg.col   <= head_beat.col;
            b1_reg.pix   <= head_beat.pix;
            b1_reg.depth <= head_beat.depth;
            b1_reg.part  <= head_beat.part;
        end
    end

    assign beat_chain[0] = b1_reg;
    assign q_chain[0]    = b1_reg.pix;

    for (genvar k = 1; k <= NROWS; k++) begin : g_cell
        dcmf_cell #(
            .INDEX    (k),
            .MAX_WIDTH(MAX_WIDTH)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .beat_i  (beat_chain[k-1]),
            .prev_q_i(q_chain[k-1]),
            .beat_o  (beat_chain[k]),
            .q_o     (q_chain[k])
        );
    end

    dcmf_hwin #(
        .MAX_RADIUS(MAX_RADIUS)
    ) u_hwin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .beat_i   (beat_chain[NROWS]),
        .q_i      (q_chain[NROWS]),
        .radius   (r_eff),
        .res_valid(hw_valid),
        .dark     (hw_dark),
        .eor      (hw_eor),
        .eof      (hw_eof)
    );

    // output register plus skid entry
    assign push = adv && hw_valid;
    assign pop  = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_dark_next   = out_dark_reg;
        out_eor_next    = out_eor_reg;
        out_eof_next    = out_eof_reg;
        skid_valid_next = skid_valid_reg;
        skid_dark_next  = skid_dark_reg;
        skid_eor_next   = skid_eor_reg;
        skid_eof_next   = skid_eof_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_dark_next   = skid_dark_reg;
                out_eor_next    = skid_eor_reg;
                out_eof_next    = skid_eof_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_dark_next  = hw_dark;
                out_eor_next   = hw_eor;
                out_eof_next   = hw_eof;
            end else begin
                skid_valid_next = 1'b1;
                skid_dark_next  = hw_dark;
                skid_eor_next   = hw_eor;
                skid_eof_next   = hw_eof;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_dark_reg  <= out_dark_next;
        out_eor_reg   <= out_eor_next;
        out_eof_reg   <= out_eof_next;
        skid_dark_reg <= skid_dark_next;
        skid_eor_reg  <= skid_eor_next;
        skid_eof_reg  <= skid_eof_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_dark_reg;
    assign m_tlast    = out_eor_reg;
    assign m_tuser[0] = out_eof_reg;

endmodule

// ----- tb/dcmf_checker.sv -----
// dcmf_checker: watches the config port and both streams of the dark channel
// minimum filter, predicts each dark value and compares it on the m_ side.
// Depends on dcmf_pkg only.
module dcmf_checker
    import dcmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [23:0]      s_tdata,    // red[7:0], green[15:8], blue[23:16]
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,    // dark_value[7:0]
    input  logic             m_tlast,    // end_of_row
    input  logic [0:0]       m_tuser,    // end_of_frame[0]
    output int               fail_count,
    output int               pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LS_ROWS = 2 * MAX_RADIUS;
    localparam int WIN_LEN = 2 * MAX_RADIUS + 1;

    typedef struct packed {
        logic [PIX_W-1:0] dark;
        logic             eor;
        logic             eof;
    } dark_exp_t;

    dark_exp_t        dark_queue[$];
    logic [PIX_W-1:0] line_mem[LS_ROWS * MAX_WIDTH];
    logic [PIX_W-1:0] col_window[WIN_LEN];
    logic [COL_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;
    logic [RAD_W-1:0] radius_reg;
    int unsigned      row_pos;
    int unsigned      col_pos;
    int               errors;

    function automatic logic [PIX_W-1:0] lesser(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    // one accepted pixel of the extended raster: column minimum over the
    // line store, horizontal window, then scan advance
    task automatic apply_pixel(input logic [23:0] data);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      p;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] colmin;
        logic [PIX_W-1:0] win;
        dark_exp_t        e;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        r = radius_reg;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        colmin = PIX_MAX;
        win = PIX_MAX;
        if (col_pos == 0) begin
            foreach (col_window[k]) col_window[k] = PIX_MAX;
        end
        if (col_pos < w) begin
            pix = PIX_MAX;
            if (row_pos < h) pix = lesser(lesser(data[7:0], data[15:8]), data[23:16]);
            colmin = pix;
            for (int unsigned i = 1; i <= 2 * r; i++) begin
                if (i <= row_pos) begin
                    p = row_pos - i;
                    if (p < h) colmin = lesser(colmin, line_mem[(p % LS_ROWS) * MAX_WIDTH + col_pos]);
                end
            end
            if (row_pos < h) line_mem[(row_pos % LS_ROWS) * MAX_WIDTH + col_pos] = pix;
        end
        for (int i = WIN_LEN - 1; i > 0; i--) col_window[i] = col_window[i-1];
        col_window[0] = colmin;
        for (int unsigned i = 0; i <= 2 * r; i++) win = lesser(win, col_window[i]);
        if (row_pos >= r && col_pos >= r && row_pos - r < h && col_pos - r < w) begin
            e.dark = win;
            e.eor = (col_pos - r == w - 1);
            e.eof = e.eor && (row_pos - r == h - 1);
            dark_queue.push_back(e);
        end
        col_pos++;
        if (col_pos >= w + r) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h + r) row_pos = 0;
        end
    endtask

    always @(posedge aclk) begin
        dark_exp_t e;
        if (!aresetn) begin
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            radius_reg = RADIUS_RST;
            row_pos = 0;
            col_pos = 0;
            errors = 0;
            dark_queue.delete();
            foreach (col_window[k]) col_window[k] = PIX_MAX;
        end else begin
            // compare before predicting: a pixel's result leaves the pipeline well after the pixel is accepted
            if (m_tvalid && m_tready) begin
                if (dark_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected result dark=%0d eor=%0d eof=%0d",
                                 $realtime, m_tdata, m_tlast, m_tuser[0]);
                end else begin
                    e = dark_queue.pop_front();
                    if (m_tdata !== e.dark || m_tlast !== e.eor || m_tuser[0] !== e.eof) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: dark mismatch: expected dark=%0d eor=%0d eof=%0d, got dark=%0d eor=%0d eof=%0d",
                                     $realtime, e.dark, e.eor, e.eof,
                                     m_tdata, m_tlast, m_tuser[0]);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WIDTH:  width_reg = cfg_wr_data[COL_W-1:0];
                    REG_HEIGHT: height_reg = cfg_wr_data[ROW_W-1:0];
                    REG_RADIUS: radius_reg = cfg_wr_data[RAD_W-1:0];
                    default: ;
                endcase
                // any write restarts the frame scan
                row_pos = 0;
                col_pos = 0;
            end
            if (s_tvalid && s_tready) apply_pixel(s_tdata);
        end
        pending_count <= dark_queue.size();
        fail_count <= errors;
    end

endmodule

// ----- tb/testbench.sv -----
// testbench: stimulus and verdict for the dark channel minimum filter.
// Depends on dcmf_pkg, the RTL under rtl/ and tb/dcmf_checker.sv.
module testbench;
    import dcmf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_RADIUS   = 7;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 2 * MAX_RADIUS + 3 + 8;
    localparam int HOLD_CYCLES  = 300;
    localparam longint LIMIT_NS = 64'd10_000_000;
    // index past the register list: changes nothing but restarts the frame
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [23:0]      s_tdata;    // red[7:0], green[15:8], blue[23:16]
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;    // dark_value[7:0]
    logic             m_tlast;    // end_of_row
    logic [0:0]       m_tuser;    // end_of_frame[0]
    int               fail_count;
    int               pending_count;

    bit idling;
    bit hold_request;
    int eff_w;
    int eff_h;
    int eff_r;
    int item_total;

    always #5 aclk = ~aclk;

    dark_channel_min_filter #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS)
    ) dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_addr, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
    );

    dcmf_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_RADIUS(MAX_RADIUS)
    ) dark_monitor (.*);

    function automatic logic [23:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        return {b, g, r};
    endfunction

    // biased toward the extremes so that ties and min edges show up often
    function automatic logic [7:0] rand_level();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'h00;
        else if (sel == 1) return 8'hFF;
        else return 8'($urandom_range(0, 255));
    endfunction

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int v;
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        case (idx)
            REG_WIDTH: begin
                v = data[COL_W-1:0];
                eff_w = (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
            end
            REG_HEIGHT: begin
                v = data[ROW_W-1:0];
                eff_h = (v < 1) ? 1 : (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
            end
            REG_RADIUS: begin
                v = data[RAD_W-1:0];
                eff_r = (v > MAX_RADIUS) ? MAX_RADIUS : v;
            end
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [23:0] data);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        item_total++;
    endtask

    task automatic send_run(input int n);
        for (int i = 0; i < n; i++) send_pixel(rgb(rand_level(), rand_level(), rand_level()));
    endtask

    // every expectation met, then DRAIN_CYCLES more for pad-only work
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // receiver: random hold-offs, one long hold on request
    initial begin
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [23:0] seq_a[12];
        int phase_no;
        int pick;
        int size;
        int n;
        logic [CFG_W-1:0] wd;
        logic [CFG_W-1:0] hd;
        logic [CFG_W-1:0] rd;
        bit full_write;

        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= REG_WIDTH;
        cfg_wr_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        idling = 1'b0;
        hold_request = 1'b0;
        item_total = 0;
        eff_w = WIDTH_RST;
        eff_h = HEIGHT_RST;
        eff_r = RADIUS_RST;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // 3x2 image, radius 1: min in each channel, extremes, pads, some carrying zeros
        seq_a = '{rgb(255, 255, 255), rgb(0, 200, 100), rgb(100, 0, 200), rgb(1, 2, 3),
                  rgb(200, 100, 0), rgb(255, 128, 255), rgb(7, 9, 8), rgb(0, 0, 0),
                  rgb(0, 0, 0), rgb(255, 255, 255), rgb(0, 0, 0), rgb(0, 0, 0)};
        cfg_write(REG_WIDTH, 13'd3);
        cfg_write(REG_HEIGHT, 13'd2);
        cfg_write(REG_RADIUS, 13'd1);
        cfg_wr_en <= 1'b0;
        foreach (seq_a[i]) send_pixel(seq_a[i]);
        wait_drained();

        // zero width and height clamp to a single pixel, radius zero
        cfg_write(REG_WIDTH, 13'd0);
        cfg_write(REG_HEIGHT, 13'd0);
        cfg_write(REG_RADIUS, 13'd0);
        cfg_wr_en <= 1'b0;
        send_pixel(rgb(0, 255, 255));
        send_pixel(rgb(255, 255, 255));
        wait_drained();

        // partial frame cut off by a write to an unused index
        cfg_write(REG_WIDTH, 13'd2);
        cfg_write(REG_HEIGHT, 13'd2);
        cfg_write(REG_RADIUS, 13'd1);
        cfg_wr_en <= 1'b0;
        send_run(4);
        wait_drained();
        cfg_write(REG_UNUSED, 13'h1ABC);
        cfg_wr_en <= 1'b0;
        send_run(9);
        wait_drained();

        item_total = 0;
        phase_no = 0;
        while (item_total < RANDOM_ITEMS) begin
            phase_no++;
            idling = (item_total < RANDOM_ITEMS * 85 / 100) && ($urandom_range(0, 3) != 0);
            if (phase_no == 1) begin
                // register maxima, clamped; only a slice of the frame
                cfg_write(REG_WIDTH, 13'd2047);
                cfg_write(REG_HEIGHT, 13'd8191);
                cfg_write(REG_RADIUS, 13'd7);
                cfg_wr_en <= 1'b0;
                send_run(200);
            end else if (phase_no == 2) begin
                // one full-width row with the receiver holding off at the start
                cfg_write(REG_WIDTH, 13'($urandom_range(1024, 2047)));
                cfg_write(REG_HEIGHT, 13'd1);
                cfg_write(REG_RADIUS, {10'($urandom), 3'd0});
                cfg_wr_en <= 1'b0;
                hold_request = 1'b1;
                send_run(MAX_WIDTH);
            end else begin
                pick = $urandom_range(0, 99);
                full_write = (pick < 8);
                if (full_write) begin
                    case ($urandom_range(0, 3))
                        0: wd = 13'd0;
                        1: wd = 13'd1;
                        2: wd = 13'd1024;
                        default: wd = 13'($urandom_range(1025, 2047));
                    endcase
                    case ($urandom_range(0, 3))
                        0: hd = 13'd0;
                        1: hd = 13'd1;
                        2: hd = 13'd4096;
                        default: hd = 13'($urandom_range(4097, 8191));
                    endcase
                    rd = $urandom_range(0, 1) ? 13'd7 : 13'd0;
                end else begin
                    wd = {2'($urandom), 11'($urandom_range(0, 9))};
                    hd = 13'($urandom_range(0, 6));
                    rd = {10'($urandom), 3'($urandom_range(0, 7))};
                end
                if (full_write || $urandom_range(0, 3) != 0) cfg_write(REG_WIDTH, wd);
                if (full_write || $urandom_range(0, 3) != 0) cfg_write(REG_HEIGHT, hd);
                if (full_write || $urandom_range(0, 3) != 0) cfg_write(REG_RADIUS, rd);
                if ($urandom_range(0, 5) == 0) cfg_write(REG_UNUSED, 13'($urandom));
                cfg_wr_en <= 1'b0;
                size = (eff_h + eff_r) * (eff_w + eff_r);
                if (size > 400) begin
                    n = $urandom_range(40, 400);
                end else begin
                    n = size * $urandom_range(1, 2);
                    if (size > 1 && $urandom_range(0, 3) == 0) n += $urandom_range(1, size - 1);
                end
                if (n > RANDOM_ITEMS - item_total) n = RANDOM_ITEMS - item_total;
                send_run(n);
            end
            wait_drained();
        end

        idling = 1'b0;
        wait_drained();
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dcmf_pkg.sv
rtl/dcmf_ram.sv
rtl/dcmf_cell.sv
rtl/dcmf_hwin.sv
rtl/dark_channel_min_filter.sv
tb/dcmf_checker.sv
tb/testbench.sv
